FILE: sv/tfn_pkg.sv
package tfn_pkg;

    localparam int VERTEX_COUNT_DEF = 1024;

    localparam int COORD_W = 24;
    localparam int SLOT_W = 10;
    localparam int NORM_W = 16;

    localparam int EDGE_W = COORD_W + 1;
    localparam int PROD_W = 2 * EDGE_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W = CROSS_W - 1;
    localparam int HALF_W = MAG_W / 2;
    localparam int SUM_W = 2 * MAG_W + 2;
    localparam int ROOT_W = SUM_W / 2;
    localparam int REM_W = ROOT_W + 3;
    localparam int QUOT_W = NORM_W - 1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TRIANGLE = 1'b1;

endpackage

FILE: sv/triangle_face_normal_top.sv
// Vertex writes transfer one per cycle while no triangle holds in_stall high, and have no result.
// A triangle reads its three corners from the single-ported vertex memory, then goes
// through three cross-product stages and a shared iterative unit: squaring by
// partial products, 51 square-root steps and 45 divide steps, the last two skipped
// for a degenerate triangle. A new triangle can enter while the unit still works on
// an earlier one. Reset clears control state only; the vertex memory holds garbage until written.
module triangle_face_normal_top
    import tfn_pkg::*;
#(
    parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      operation,
    input  logic [SLOT_W-1:0]         vertex_slot,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic signed [COORD_W-1:0] coord_z,
    input  logic [SLOT_W-1:0]         corner_a,
    input  logic [SLOT_W-1:0]         corner_b,
    input  logic [SLOT_W-1:0]         corner_c,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [NORM_W-1:0]  normal_x,
    output logic signed [NORM_W-1:0]  normal_y,
    output logic signed [NORM_W-1:0]  normal_z,
    output logic                      degenerate
);

    localparam int ADDR_W = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam int VERT_W = 3 * COORD_W;

    typedef enum logic [1:0] {F_IDLE, F_RB, F_RC, F_LAST} front_t;
    typedef enum logic [2:0] {B_IDLE, B_SQ, B_ROOT, B_DIV, B_OUT} back_t;

    // ---------------- vertex memory ----------------
    logic [VERT_W-1:0] vert_mem [VERTEX_COUNT];
    logic [VERT_W-1:0] rdata_reg;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            vert_mem[mem_addr] <= {coord_z, coord_y, coord_x};
        end
        if (mem_re)
        begin
            rdata_reg <= vert_mem[mem_addr];
        end
    end

    // ---------------- front end ----------------
    front_t            front_reg;
    logic [ADDR_W-1:0] addr_b_reg, addr_c_reg;
    logic              ok_a_reg, ok_b_reg, ok_c_reg;
    logic [VERT_W-1:0] va_reg, vb_reg;
    logic              in_xfer;
    logic              slot_ok, a_ok, b_ok, c_ok;
    logic              e_take;
    logic [VERT_W-1:0] vc;

    assign slot_ok = 32'(vertex_slot) < VERTEX_COUNT;
    assign a_ok = 32'(corner_a) < VERTEX_COUNT;
    assign b_ok = 32'(corner_b) < VERTEX_COUNT;
    assign c_ok = 32'(corner_c) < VERTEX_COUNT;

    always_comb
    begin
        unique case (front_reg)
            F_IDLE:  in_stall = 1'b0;
            F_LAST:  in_stall = !e_take;
            default: in_stall = 1'b1;
        endcase
    end

    assign in_xfer = in_valid && !in_stall;

    always_comb
    begin
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_addr = ADDR_W'(vertex_slot);
        unique case (front_reg)
            F_RB:
            begin
                mem_re = 1'b1;
                mem_addr = addr_b_reg;
            end
            F_RC:
            begin
                mem_re = 1'b1;
                mem_addr = addr_c_reg;
            end
            default:
            begin
                if (in_xfer && operation == OP_WRITE)
                begin
                    mem_we = slot_ok;
                end
                else if (in_xfer)
                begin
                    mem_re = 1'b1;
                    mem_addr = ADDR_W'(corner_a);
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= F_IDLE;
        end
        else
        begin
            unique case (front_reg)
                F_RB:
                begin
                    va_reg <= ok_a_reg ? rdata_reg : '0;
                    front_reg <= F_RC;
                end
                F_RC:
                begin
                    vb_reg <= ok_b_reg ? rdata_reg : '0;
                    front_reg <= F_LAST;
                end
                default:
                begin
                    if (front_reg == F_LAST && !e_take)
                    begin
                        front_reg <= F_LAST;
                    end
                    else if (in_xfer && operation == OP_TRIANGLE)
                    begin
                        addr_b_reg <= ADDR_W'(corner_b);
                        addr_c_reg <= ADDR_W'(corner_c);
                        ok_a_reg <= a_ok;
                        ok_b_reg <= b_ok;
                        ok_c_reg <= c_ok;
                        front_reg <= F_RB;
                    end
                    else
                    begin
                        front_reg <= F_IDLE;
                    end
                end
            endcase
        end
    end

    assign vc = ok_c_reg ? rdata_reg : '0;

    // ---------------- cross product pipeline ----------------
    logic                      e_vld_reg, p_vld_reg, n_vld_reg;
    logic                      e_go, p_go, n_go;
    logic signed [EDGE_W-1:0]  e1_reg [3];
    logic signed [EDGE_W-1:0]  e2_reg [3];
    logic signed [PROD_W-1:0]  p_reg [6];
    logic signed [CROSS_W-1:0] n_reg [3];
    logic                      e_load;
    back_t                     back_reg;

    assign n_go = n_vld_reg && back_reg == B_IDLE;
    assign p_go = p_vld_reg && (!n_vld_reg || n_go);
    assign e_go = e_vld_reg && (!p_vld_reg || p_go);
    assign e_take = !e_vld_reg || e_go;
    assign e_load = front_reg == F_LAST && e_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg <= 1'b0;
            p_vld_reg <= 1'b0;
            n_vld_reg <= 1'b0;
        end
        else
        begin
            if (e_load)
            begin
                e_vld_reg <= 1'b1;
            end
            else if (e_go)
            begin
                e_vld_reg <= 1'b0;
            end
            if (e_go)
            begin
                p_vld_reg <= 1'b1;
            end
            else if (p_go)
            begin
                p_vld_reg <= 1'b0;
            end
            if (p_go)
            begin
                n_vld_reg <= 1'b1;
            end
            else if (n_go)
            begin
                n_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_load)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e1_reg[k] <= EDGE_W'($signed(vb_reg[k*COORD_W +: COORD_W]))
                           - EDGE_W'($signed(va_reg[k*COORD_W +: COORD_W]));
                e2_reg[k] <= EDGE_W'($signed(vc[k*COORD_W +: COORD_W]))
                           - EDGE_W'($signed(va_reg[k*COORD_W +: COORD_W]));
            end
        end
        if (e_go)
        begin
            p_reg[0] <= e1_reg[1] * e2_reg[2];
            p_reg[1] <= e1_reg[2] * e2_reg[1];
            p_reg[2] <= e1_reg[2] * e2_reg[0];
            p_reg[3] <= e1_reg[0] * e2_reg[2];
            p_reg[4] <= e1_reg[0] * e2_reg[1];
            p_reg[5] <= e1_reg[1] * e2_reg[0];
        end
        if (p_go)
        begin
            for (int k = 0; k < 3; k++)
            begin
                n_reg[k] <= CROSS_W'(p_reg[2*k]) - CROSS_W'(p_reg[2*k+1]);
            end
        end
    end

    // ---------------- length and scaling unit ----------------
    logic [MAG_W-1:0]       mag_reg [3];
    logic [2:0]             sign_reg;
    logic [5:0]             cnt_reg;
    logic [1:0]             comp_reg;
    logic [SUM_W-1:0]       acc_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [1:0]             part_reg;
    logic                   prod_vld_reg;
    logic [SUM_W-1:0]       rad_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [ROOT_W-1:0]      root_reg;
    logic [ROOT_W:0]        r_reg;
    logic [QUOT_W-1:0]      q_reg;
    logic [NORM_W-1:0]      res_reg [3];
    logic                   degen_reg;
    logic                   out_vld_reg;
    logic [NORM_W-1:0]      out_x_reg, out_y_reg, out_z_reg;
    logic                   out_degen_reg;

    logic [HALF_W-1:0]      mul_a, mul_b;
    logic [MAG_W-1:0]       mag_sel;
    logic [SUM_W-1:0]       acc_next;
    logic [REM_W-1:0]       rem_sh, trial, rem_sub;
    logic                   root_ge;
    logic                   div_ge;
    logic [ROOT_W:0]        r_sub;
    logic [QUOT_W-1:0]      q_next;
    logic [NORM_W-1:0]      q_signed;
    logic                   out_free;

    always_comb
    begin
        mag_sel = mag_reg[cnt_reg[3:2]];
        mul_a = cnt_reg[1] ? mag_sel[MAG_W-1:HALF_W] : mag_sel[HALF_W-1:0];
        mul_b = cnt_reg[0] ? mag_sel[MAG_W-1:HALF_W] : mag_sel[HALF_W-1:0];
        // Cross terms carry one half-width shift, the high-by-high term two.
        acc_next = acc_reg;
        if (prod_vld_reg)
        begin
            case (part_reg)
                2'd0:    acc_next = acc_reg + SUM_W'(prod_reg);
                2'd3:    acc_next = acc_reg + (SUM_W'(prod_reg) << (2 * HALF_W));
                default: acc_next = acc_reg + (SUM_W'(prod_reg) << HALF_W);
            endcase
        end

        rem_sh = {rem_reg[REM_W-3:0], rad_reg[SUM_W-1 -: 2]};
        trial = {1'b0, root_reg, 2'b01};
        root_ge = rem_sh >= trial;
        rem_sub = root_ge ? rem_sh - trial : rem_sh;

        div_ge = r_reg >= {1'b0, root_reg};
        r_sub = div_ge ? r_reg - {1'b0, root_reg} : r_reg;
        q_next = {q_reg[QUOT_W-2:0], div_ge};
        q_signed = sign_reg[comp_reg] ? -{1'b0, q_next} : {1'b0, q_next};
    end

    assign out_free = !out_vld_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            back_reg <= B_IDLE;
            out_vld_reg <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            if (out_vld_reg && !out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
            unique case (back_reg)
                B_IDLE:
                begin
                    if (n_go)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            sign_reg[k] <= n_reg[k][CROSS_W-1];
                            mag_reg[k] <= n_reg[k][CROSS_W-1] ? MAG_W'(-n_reg[k])
                                                              : MAG_W'(n_reg[k]);
                        end
                        acc_reg <= '0;
                        cnt_reg <= '0;
                        prod_vld_reg <= 1'b0;
                        back_reg <= B_SQ;
                    end
                end
                B_SQ:
                begin
                    acc_reg <= acc_next;
                    prod_reg <= mul_a * mul_b;
                    part_reg <= cnt_reg[1:0];
                    prod_vld_reg <= 1'b1;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd12)
                    begin
                        prod_vld_reg <= 1'b0;
                        if (acc_next == '0)
                        begin
                            degen_reg <= 1'b1;
                            for (int k = 0; k < 3; k++)
                            begin
                                res_reg[k] <= '0;
                            end
                            back_reg <= B_OUT;
                        end
                        else
                        begin
                            degen_reg <= 1'b0;
                            rad_reg <= acc_next;
                            rem_reg <= '0;
                            root_reg <= '0;
                            cnt_reg <= 6'(ROOT_W - 1);
                            back_reg <= B_ROOT;
                        end
                    end
                end
                B_ROOT:
                begin
                    rem_reg <= rem_sub;
                    root_reg <= {root_reg[ROOT_W-2:0], root_ge};
                    rad_reg <= rad_reg << 2;
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == '0)
                    begin
                        comp_reg <= '0;
                        r_reg <= (ROOT_W + 1)'(mag_reg[0]);
                        q_reg <= '0;
                        cnt_reg <= 6'(QUOT_W - 1);
                        back_reg <= B_DIV;
                    end
                end
                B_DIV:
                begin
                    q_reg <= q_next;
                    r_reg <= r_sub << 1;
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == '0)
                    begin
                        res_reg[comp_reg] <= q_signed;
                        q_reg <= '0;
                        cnt_reg <= 6'(QUOT_W - 1);
                        if (comp_reg == 2'd2)
                        begin
                            back_reg <= B_OUT;
                        end
                        else
                        begin
                            comp_reg <= comp_reg + 2'd1;
                            r_reg <= (ROOT_W + 1)'(mag_reg[comp_reg + 2'd1]);
                        end
                    end
                end
                B_OUT:
                begin
                    if (out_free)
                    begin
                        out_vld_reg <= 1'b1;
                        out_x_reg <= res_reg[0];
                        out_y_reg <= res_reg[1];
                        out_z_reg <= res_reg[2];
                        out_degen_reg <= degen_reg;
                        back_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    back_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_vld_reg;
    assign normal_x = out_x_reg;
    assign normal_y = out_y_reg;
    assign normal_z = out_z_reg;
    assign degenerate = out_degen_reg;

endmodule

FILE: test/tb_triangle_face_normal_top.sv
module tb_triangle_face_normal_top;
    import tfn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1500;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AT_ITEM = 1100;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
        logic                     degen;
    } normal_t;

    typedef struct {
        logic                      op;
        logic [SLOT_W-1:0]         slot;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [SLOT_W-1:0]         a;
        logic [SLOT_W-1:0]         b;
        logic [SLOT_W-1:0]         c;
        logic                      typed;
        normal_t                   want;
    } stim_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic                      operation;
    logic [SLOT_W-1:0]         vertex_slot;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [SLOT_W-1:0]         corner_a;
    logic [SLOT_W-1:0]         corner_b;
    logic [SLOT_W-1:0]         corner_c;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [NORM_W-1:0]  normal_x;
    logic signed [NORM_W-1:0]  normal_y;
    logic signed [NORM_W-1:0]  normal_z;
    logic                      degenerate;

    // Shadow copy of the vertex memory and which slots hold defined data.
    logic signed [COORD_W-1:0] shadow_x [VERTEX_COUNT_DEF];
    logic signed [COORD_W-1:0] shadow_y [VERTEX_COUNT_DEF];
    logic signed [COORD_W-1:0] shadow_z [VERTEX_COUNT_DEF];
    bit                        slot_written [VERTEX_COUNT_DEF];
    int                        written_slots [$];

    normal_t pending_normals [$];
    int      error_count = 0;
    int      tx_idle_pct = 34;
    int      rx_idle_pct = 68;
    bit      hold_request = 0;
    int      quiet_cycles = 0;

    triangle_face_normal_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .vertex_slot(vertex_slot),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .coord_z    (coord_z),
        .corner_a   (corner_a),
        .corner_b   (corner_b),
        .corner_c   (corner_c),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .normal_x   (normal_x),
        .normal_y   (normal_y),
        .normal_z   (normal_z),
        .degenerate (degenerate)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic logic signed [NORM_W-1:0] scale_to_unit(longint comp,
                                                               logic [127:0] len);
        logic [127:0] mag;
        logic [127:0] quot;
        mag = comp < 0 ? 128'(-comp) : 128'(comp);
        quot = (mag << 14) / len;
        if (comp < 0)
        begin
            quot = -quot;
        end
        return quot[NORM_W-1:0];
    endfunction

    function automatic normal_t face_normal(int sa, int sb, int sc);
        longint       e1 [3];
        longint       e2 [3];
        longint       n [3];
        logic [127:0] mag;
        logic [127:0] sum;
        logic [127:0] root;
        logic [127:0] cand;
        normal_t      res;
        e1[0] = longint'(shadow_x[sb]) - longint'(shadow_x[sa]);
        e1[1] = longint'(shadow_y[sb]) - longint'(shadow_y[sa]);
        e1[2] = longint'(shadow_z[sb]) - longint'(shadow_z[sa]);
        e2[0] = longint'(shadow_x[sc]) - longint'(shadow_x[sa]);
        e2[1] = longint'(shadow_y[sc]) - longint'(shadow_y[sa]);
        e2[2] = longint'(shadow_z[sc]) - longint'(shadow_z[sa]);
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        sum = '0;
        for (int k = 0; k < 3; k++)
        begin
            mag = n[k] < 0 ? 128'(-n[k]) : 128'(n[k]);
            sum += mag * mag;
        end
        if (sum == 0)
        begin
            res.nx = '0;
            res.ny = '0;
            res.nz = '0;
            res.degen = 1'b1;
            return res;
        end
        root = '0;
        for (int bit_idx = 50; bit_idx >= 0; bit_idx--)
        begin
            cand = root | (128'd1 << bit_idx);
            if (cand * cand <= sum)
            begin
                root = cand;
            end
        end
        res.nx = scale_to_unit(n[0], root);
        res.ny = scale_to_unit(n[1], root);
        res.nz = scale_to_unit(n[2], root);
        res.degen = 1'b0;
        return res;
    endfunction

    // Updates the shadow memory or queues the expected normal for one transfer.
    task automatic record_transfer(stim_row_t row);
        if (row.op == OP_WRITE)
        begin
            shadow_x[row.slot] = row.x;
            shadow_y[row.slot] = row.y;
            shadow_z[row.slot] = row.z;
            if (!slot_written[row.slot])
            begin
                slot_written[row.slot] = 1'b1;
                written_slots = {written_slots, int'(row.slot)};
            end
        end
        else if (row.typed)
        begin
            pending_normals = {pending_normals, row.want};
        end
        else
        begin
            pending_normals = {pending_normals,
                               face_normal(int'(row.a), int'(row.b), int'(row.c))};
        end
    endtask

    task automatic send_item(stim_row_t row);
        int gap;
        in_valid <= 1'b1;
        operation <= row.op;
        vertex_slot <= row.slot;
        coord_x <= row.x;
        coord_y <= row.y;
        coord_z <= row.z;
        corner_a <= row.a;
        corner_b <= row.b;
        corner_c <= row.c;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        record_transfer(row);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            gap = $urandom_range(4, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic stim_row_t write_row(int slot, int x, int y, int z);
        stim_row_t row;
        row = '{default: '0};
        row.op = OP_WRITE;
        row.slot = SLOT_W'(slot);
        row.x = COORD_W'(x);
        row.y = COORD_W'(y);
        row.z = COORD_W'(z);
        row.a = SLOT_W'($urandom());
        row.b = SLOT_W'($urandom());
        row.c = SLOT_W'($urandom());
        return row;
    endfunction

    function automatic stim_row_t tri_row(int a, int b, int c);
        stim_row_t row;
        row = '{default: '0};
        row.op = OP_TRIANGLE;
        row.slot = SLOT_W'($urandom());
        row.x = COORD_W'($urandom());
        row.y = COORD_W'($urandom());
        row.z = COORD_W'($urandom());
        row.a = SLOT_W'(a);
        row.b = SLOT_W'(b);
        row.c = SLOT_W'(c);
        return row;
    endfunction

    function automatic stim_row_t typed_row(int a, int b, int c, int nx, int ny, int nz,
                                            bit degen);
        stim_row_t row;
        row = tri_row(a, b, c);
        row.typed = 1'b1;
        row.want.nx = NORM_W'(nx);
        row.want.ny = NORM_W'(ny);
        row.want.nz = NORM_W'(nz);
        row.want.degen = degen;
        return row;
    endfunction

    // Sender: directed table first, then random traffic in three idle phases.
    initial
    begin
        stim_row_t directed [$];
        stim_row_t row;
        int        pick;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_WRITE;
        vertex_slot = '0;
        coord_x = '0;
        coord_y = '0;
        coord_z = '0;
        corner_a = '0;
        corner_b = '0;
        corner_c = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = {directed, write_row(0, 0, 0, 0)};
        directed = {directed, write_row(1, 4096, 0, 0)};
        directed = {directed, write_row(2, 0, 4096, 0)};
        directed = {directed, write_row(3, 0, 0, 4096)};
        directed = {directed, typed_row(0, 1, 2, 0, 0, 16384, 1'b0)};
        directed = {directed, typed_row(2, 1, 0, 0, 0, -16384, 1'b0)};
        directed = {directed, typed_row(0, 2, 3, 16384, 0, 0, 1'b0)};
        directed = {directed, typed_row(0, 0, 0, 0, 0, 0, 1'b1)};
        directed = {directed, write_row(1023, 8388607, 8388607, 8388607)};
        directed = {directed, write_row(512, -8388608, -8388608, -8388608)};
        directed = {directed, write_row(341, -8388608, 8388607, 0)};
        directed = {directed, write_row(682, 8388607, -8388608, -1)};
        // Corners on one line through the origin give a zero cross product.
        directed = {directed, typed_row(0, 1023, 512, 0, 0, 0, 1'b1)};
        directed = {directed, tri_row(1023, 512, 341)};
        directed = {directed, tri_row(341, 682, 1023)};
        directed = {directed, tri_row(682, 341, 512)};
        directed = {directed, tri_row(1, 1023, 682)};
        foreach (directed[i])
        begin
            send_item(directed[i]);
        end

        for (int item = 0; item < RANDOM_ITEMS; item++)
        begin
            if (item == RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 68;
                rx_idle_pct = 34;
            end
            if (item == 2 * RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (item == HOLD_AT_ITEM)
            begin
                hold_request = 1'b1;
            end
            if ($urandom_range(99) < 45)
            begin
                pick = $urandom_range(3);
                if (pick == 0)
                begin
                    row = write_row($urandom_range(1023), $urandom_range(8191) - 4096,
                                    $urandom_range(8191) - 4096,
                                    $urandom_range(8191) - 4096);
                end
                else
                begin
                    row = write_row($urandom_range(1023), $urandom(), $urandom(),
                                    $urandom());
                end
            end
            else
            begin
                row = tri_row(written_slots[$urandom_range(written_slots.size() - 1)],
                              written_slots[$urandom_range(written_slots.size() - 1)],
                              written_slots[$urandom_range(written_slots.size() - 1)]);
                if ($urandom_range(9) == 0)
                begin
                    row.c = row.a;
                end
            end
            send_item(row);
        end
        in_valid <= 1'b0;

        while (pending_normals.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Receiver: random back-pressure, plus one long hold-off to fill the pipe.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        normal_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_normals.size() == 0)
            begin
                $error("unexpected result transfer");
                error_count++;
            end
            else
            begin
                want = pending_normals.pop_front();
                if (normal_x !== want.nx)
                begin
                    $error("normal_x expected %0d actual %0d", want.nx, normal_x);
                    error_count++;
                end
                if (normal_y !== want.ny)
                begin
                    $error("normal_y expected %0d actual %0d", want.ny, normal_y);
                    error_count++;
                end
                if (normal_z !== want.nz)
                begin
                    $error("normal_z expected %0d actual %0d", want.nz, normal_z);
                    error_count++;
                end
                if (degenerate !== want.degen)
                begin
                    $error("degenerate expected %0d actual %0d", want.degen, degenerate);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

FILE: files.f
sv/tfn_pkg.sv
sv/triangle_face_normal_top.sv
test/tb_triangle_face_normal_top.sv
